>>> hdl/mlpf_pkg.sv
`timescale 1ns / 1ps
package mlpf_pkg;

  localparam int OP_W     = 2;
  localparam int LEVEL_W  = 4;
  localparam int VALUE_W  = 32;
  localparam int COUNT_W  = 7;
  localparam int STATUS_W = 3;
  localparam int TOTAL_W  = 9;

  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
  localparam logic [OP_W-1:0] OP_MOVE   = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_BAD_LEVEL = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd2;
  localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd3;
  localparam logic [STATUS_W-1:0] ST_BAD_MOVE  = 3'd4;

endpackage

>>> hdl/mlpf_node_store.sv
`timescale 1ns / 1ps
module mlpf_node_store
  import mlpf_pkg::*;
#(
  parameter int CAPACITY = 256,
  parameter int NW       = $clog2(CAPACITY)
) (
  input  logic               clk,
  input  logic               val_we,
  input  logic [NW-1:0]      val_addr,
  input  logic [VALUE_W-1:0] val_wdata,
  input  logic               lnk_we,
  input  logic [NW-1:0]      lnk_addr,
  input  logic [NW-1:0]      lnk_wdata,
  input  logic [NW-1:0]      rd_addr,
  output logic [VALUE_W-1:0] rd_value,
  output logic [NW-1:0]      rd_link
);

  logic [VALUE_W-1:0] node_value [CAPACITY];
  logic [NW-1:0]      node_link  [CAPACITY];

  always_ff @(posedge clk) begin
    if (val_we) begin
      node_value[val_addr] <= val_wdata;
    end
    if (lnk_we) begin
      node_link[lnk_addr] <= lnk_wdata;
    end
    rd_value <= node_value[rd_addr];
    rd_link  <= node_link[rd_addr];
  end

endmodule

>>> hdl/mlpf_level_table.sv
`timescale 1ns / 1ps
module mlpf_level_table #(
  parameter int LEVELS = 8,
  parameter int NW     = 8,
  parameter int CW     = 9,
  parameter int LW     = $clog2(LEVELS)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          we,
  input  logic [LW-1:0] waddr,
  input  logic [NW-1:0] whead,
  input  logic [NW-1:0] wtail,
  input  logic [CW-1:0] wsize,
  input  logic [LW-1:0] raddr,
  output logic [NW-1:0] rhead,
  output logic [NW-1:0] rtail,
  output logic [CW-1:0] rsize
);

  logic [NW-1:0] level_head [LEVELS];
  logic [NW-1:0] level_tail [LEVELS];
  logic [CW-1:0] level_size [LEVELS];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < LEVELS; i++) begin
        level_head[i] <= '0;
        level_tail[i] <= '0;
        level_size[i] <= '0;
      end
    end else if (we) begin
      level_head[waddr] <= whead;
      level_tail[waddr] <= wtail;
      level_size[waddr] <= wsize;
    end
  end

  assign rhead = level_head[raddr];
  assign rtail = level_tail[raddr];
  assign rsize = level_size[raddr];

endmodule

>>> hdl/multi_level_priority_fifo_top.sv
// Multi-level priority FIFO: one linked FIFO per level in a shared node store.
// Command channel: an operation is taken on a rising edge with start high and
// busy low; opcode, level, target_level, item_value and remove_count are
// sampled on that edge. Insert appends item_value to a level, remove takes up
// to remove_count entries from a level head, move splices one level onto the
// tail of another.
// Result channel: every result is shown for one cycle with strobe high; the
// receiver cannot stall it. Each result carries status, total_count and
// store_empty; removed entries come with out_valid high, one per cycle, and
// the final result of an operation has last high.
// Sequence: every operation is first evaluated in S_EVAL, and each result leaves
// through the output registers. Insert from fresh nodes and errors finish in
// S_EVAL; insert reusing a released node adds S_INS_FIN, move adds S_MOVE and
// remove walks S_REM once per entry. The node store has a single registered
// read port and the remove walk reads one node per cycle through it.
// Reset: all levels empty, free list empty, nothing pending; the node store
// needs no clearing pass.
`timescale 1ns / 1ps
module multi_level_priority_fifo_top
  import mlpf_pkg::*;
#(
  parameter int LEVELS     = 8,
  parameter int CAPACITY   = 256,
  parameter int MAX_REMOVE = 64
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  logic [OP_W-1:0]            opcode,
  input  logic [LEVEL_W-1:0]         level,
  input  logic [LEVEL_W-1:0]         target_level,
  input  logic signed [VALUE_W-1:0]  item_value,
  input  logic [COUNT_W-1:0]         remove_count,
  output logic                       strobe,
  output logic [STATUS_W-1:0]        status,
  output logic signed [VALUE_W-1:0]  out_value,
  output logic                       out_valid,
  output logic                       last,
  output logic [TOTAL_W-1:0]         total_count,
  output logic                       store_empty
);

  localparam int NW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int LW = $clog2(LEVELS);
  localparam int TW = (CW > COUNT_W) ? CW : COUNT_W;

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_EVAL    = 3'd1;
  localparam logic [2:0] S_INS_FIN = 3'd2;
  localparam logic [2:0] S_REM     = 3'd3;
  localparam logic [2:0] S_MOVE    = 3'd4;

  logic [2:0]           state, state_next;
  logic [OP_W-1:0]      op_q;
  logic [LEVEL_W-1:0]   lv_q, tg_q;
  logic [VALUE_W-1:0]   val_q;
  logic [COUNT_W-1:0]   cnt_q;

  logic [NW-1:0]        free_head, free_head_next;
  logic [CW-1:0]        free_size, free_size_next;
  logic [CW-1:0]        fresh_mark, fresh_mark_next;
  logic [CW-1:0]        entry_total, entry_total_next;
  logic [NW-1:0]        cur, cur_next;
  logic [COUNT_W-1:0]   remain, remain_next;
  logic [NW-1:0]        src_head, src_head_next;
  logic [NW-1:0]        src_tail, src_tail_next;
  logic [CW-1:0]        src_size, src_size_next;

  logic                 val_we, lnk_we;
  logic [NW-1:0]        val_addr, lnk_addr, lnk_wdata, rd_addr;
  logic [VALUE_W-1:0]   rd_value;
  logic [NW-1:0]        rd_link;

  logic                 lt_we;
  logic [LW-1:0]        lt_waddr, lt_raddr, lv_idx, tg_idx;
  logic [NW-1:0]        lt_whead, lt_wtail, lt_head, lt_tail;
  logic [CW-1:0]        lt_wsize, lt_size;

  logic                 lv_ok, tg_ok;
  logic [NW-1:0]        alloc;
  logic [TW-1:0]        take_w;

  logic                 emit;
  logic [STATUS_W-1:0]  res_status;
  logic [VALUE_W-1:0]   res_value;
  logic                 res_valid, res_last;
  logic [CW-1:0]        res_total;

  mlpf_node_store #(
    .CAPACITY (CAPACITY),
    .NW       (NW)
  ) u_store (
    .clk       (clk),
    .val_we    (val_we),
    .val_addr  (val_addr),
    .val_wdata (val_q),
    .lnk_we    (lnk_we),
    .lnk_addr  (lnk_addr),
    .lnk_wdata (lnk_wdata),
    .rd_addr   (rd_addr),
    .rd_value  (rd_value),
    .rd_link   (rd_link)
  );

  mlpf_level_table #(
    .LEVELS (LEVELS),
    .NW     (NW),
    .CW     (CW),
    .LW     (LW)
  ) u_levels (
    .clk   (clk),
    .rst   (rst),
    .we    (lt_we),
    .waddr (lt_waddr),
    .whead (lt_whead),
    .wtail (lt_wtail),
    .wsize (lt_wsize),
    .raddr (lt_raddr),
    .rhead (lt_head),
    .rtail (lt_tail),
    .rsize (lt_size)
  );

  assign busy     = (state != S_IDLE);
  assign lv_idx   = lv_q[LW-1:0];
  assign tg_idx   = tg_q[LW-1:0];
  assign lt_raddr = (state == S_MOVE) ? tg_idx : lv_idx;
  assign lv_ok    = ({1'b0, lv_q} < 5'(LEVELS));
  assign tg_ok    = ({1'b0, tg_q} < 5'(LEVELS));
  // reuse a released node first, else take the next never-used one
  assign alloc    = (free_size != '0) ? free_head : fresh_mark[NW-1:0];

  // cap the run at the level's size and at the per-command limit
  always_comb begin
    take_w = TW'(cnt_q);
    if (TW'(lt_size) < take_w) begin
      take_w = TW'(lt_size);
    end
    if (take_w > TW'(MAX_REMOVE)) begin
      take_w = TW'(MAX_REMOVE);
    end
  end

  always_comb begin
    state_next       = state;
    free_head_next   = free_head;
    free_size_next   = free_size;
    fresh_mark_next  = fresh_mark;
    entry_total_next = entry_total;
    cur_next         = cur;
    remain_next      = remain;
    src_head_next    = src_head;
    src_tail_next    = src_tail;
    src_size_next    = src_size;
    val_we           = 1'b0;
    val_addr         = alloc;
    lnk_we           = 1'b0;
    lnk_addr         = cur;
    lnk_wdata        = free_head;
    rd_addr          = free_head;
    lt_we            = 1'b0;
    lt_waddr         = lv_idx;
    lt_whead         = lt_head;
    lt_wtail         = lt_tail;
    lt_wsize         = lt_size;
    emit             = 1'b0;
    res_status       = ST_OK;
    res_value        = '0;
    res_valid        = 1'b0;
    res_last         = 1'b1;

    unique case (state)
      S_IDLE: begin
        if (start) begin
          state_next = S_EVAL;
        end
      end
      S_EVAL: begin
        state_next = S_IDLE;
        case (op_q)
          OP_INSERT: begin
            if (!lv_ok) begin
              emit       = 1'b1;
              res_status = ST_BAD_LEVEL;
            end else if (entry_total >= CW'(CAPACITY)) begin
              emit       = 1'b1;
              res_status = ST_FULL;
            end else begin
              val_we = 1'b1;
              if (lt_size != '0) begin
                lnk_we    = 1'b1;
                lnk_addr  = lt_tail;
                lnk_wdata = alloc;
              end
              lt_we            = 1'b1;
              lt_whead         = (lt_size == '0) ? alloc : lt_head;
              lt_wtail         = alloc;
              lt_wsize         = lt_size + 1'b1;
              entry_total_next = entry_total + 1'b1;
              if (free_size != '0) begin
                // fetch the successor of the free-list head
                rd_addr        = free_head;
                free_size_next = free_size - 1'b1;
                state_next     = S_INS_FIN;
              end else begin
                fresh_mark_next = fresh_mark + 1'b1;
                emit            = 1'b1;
              end
            end
          end
          OP_REMOVE: begin
            if (!lv_ok) begin
              emit       = 1'b1;
              res_status = ST_BAD_LEVEL;
            end else if (lt_size == '0 || cnt_q == '0) begin
              emit       = 1'b1;
              res_status = ST_EMPTY;
            end else begin
              rd_addr          = lt_head;
              cur_next         = lt_head;
              remain_next      = COUNT_W'(take_w);
              lt_we            = 1'b1;
              lt_wsize         = lt_size - CW'(take_w);
              entry_total_next = entry_total - CW'(take_w);
              state_next       = S_REM;
            end
          end
          OP_MOVE: begin
            if (!lv_ok || !tg_ok) begin
              emit       = 1'b1;
              res_status = ST_BAD_LEVEL;
            end else if (lv_q == tg_q) begin
              emit       = 1'b1;
              res_status = ST_BAD_MOVE;
            end else if (lt_size == '0) begin
              emit       = 1'b1;
              res_status = ST_EMPTY;
            end else begin
              src_head_next = lt_head;
              src_tail_next = lt_tail;
              src_size_next = lt_size;
              lt_we         = 1'b1;
              lt_whead      = '0;
              lt_wtail      = '0;
              lt_wsize      = '0;
              state_next    = S_MOVE;
            end
          end
          default: begin
            emit       = 1'b1;
            res_status = ST_BAD_MOVE;
          end
        endcase
      end
      S_INS_FIN: begin
        free_head_next = rd_link;
        emit           = 1'b1;
        state_next     = S_IDLE;
      end
      S_REM: begin
        emit      = 1'b1;
        res_value = rd_value;
        res_valid = 1'b1;
        res_last  = (remain == COUNT_W'(1));
        // release the node just read onto the free list, advance to its link
        lnk_we         = 1'b1;
        lnk_addr       = cur;
        lnk_wdata      = free_head;
        free_head_next = cur;
        free_size_next = free_size + 1'b1;
        rd_addr        = rd_link;
        cur_next       = rd_link;
        remain_next    = remain - 1'b1;
        if (remain == COUNT_W'(1)) begin
          lt_we      = 1'b1;
          lt_whead   = (lt_size == '0) ? '0 : rd_link;
          lt_wtail   = (lt_size == '0) ? '0 : lt_tail;
          state_next = S_IDLE;
        end
      end
      S_MOVE: begin
        lt_we    = 1'b1;
        lt_waddr = tg_idx;
        if (lt_size == '0) begin
          lt_whead = src_head;
        end else begin
          lnk_we    = 1'b1;
          lnk_addr  = lt_tail;
          lnk_wdata = src_head;
        end
        lt_wtail   = src_tail;
        lt_wsize   = lt_size + src_size;
        emit       = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase

    res_total = entry_total_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      free_head   <= '0;
      free_size   <= '0;
      fresh_mark  <= '0;
      entry_total <= '0;
      remain      <= '0;
      strobe      <= 1'b0;
    end else begin
      state       <= state_next;
      free_head   <= free_head_next;
      free_size   <= free_size_next;
      fresh_mark  <= fresh_mark_next;
      entry_total <= entry_total_next;
      remain      <= remain_next;
      strobe      <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && start) begin
      op_q  <= opcode;
      lv_q  <= level;
      tg_q  <= target_level;
      val_q <= item_value;
      cnt_q <= remove_count;
    end
    cur         <= cur_next;
    src_head    <= src_head_next;
    src_tail    <= src_tail_next;
    src_size    <= src_size_next;
    status      <= res_status;
    out_value   <= res_value;
    out_valid   <= res_valid;
    last        <= res_last;
    total_count <= TOTAL_W'(res_total);
    store_empty <= (res_total == '0);
  end

`ifndef SYNTHESIS
  a_run_contiguous: assert property (@(posedge clk) disable iff (rst)
    strobe && !last |=> strobe && out_valid)
    else $error("removal run broken before its last transfer");

  a_single_result: assert property (@(posedge clk) disable iff (rst)
    strobe && !out_valid |-> last)
    else $error("non-data result not marked last");

  a_node_balance: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> fresh_mark == entry_total + free_size)
    else $error("node accounting out of balance");

  a_total_bound: assert property (@(posedge clk) disable iff (rst)
    entry_total <= CW'(CAPACITY))
    else $error("entry total above capacity");
`endif

endmodule

>>> tb/multi_level_priority_fifo_top_test.sv
`timescale 1ns / 1ps
module multi_level_priority_fifo_top_test;
  import mlpf_pkg::*;

  localparam int LEVELS       = 8;
  localparam int CAPACITY     = 256;
  localparam int MAX_REMOVE   = 64;
  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 100;
  localparam logic [OP_W-1:0] OP_SPARE = 2'd3;

  typedef struct {
    logic [OP_W-1:0]           op;
    logic [LEVEL_W-1:0]        lvl;
    logic [LEVEL_W-1:0]        dst;
    logic signed [VALUE_W-1:0] val;
    logic [COUNT_W-1:0]        cnt;
  } command_t;

  typedef struct {
    logic [STATUS_W-1:0]       status;
    logic signed [VALUE_W-1:0] value;
    logic                      valid;
    logic                      last;
    logic [TOTAL_W-1:0]        total;
    logic                      empty;
  } outcome_t;

  logic                      clk          = 1'b0;
  logic                      rst          = 1'b1;
  logic                      start        = 1'b0;
  logic [OP_W-1:0]           opcode       = OP_INSERT;
  logic [LEVEL_W-1:0]        level        = '0;
  logic [LEVEL_W-1:0]        target_level = '0;
  logic signed [VALUE_W-1:0] item_value   = '0;
  logic [COUNT_W-1:0]        remove_count = '0;
  logic                      busy;
  logic                      strobe;
  logic [STATUS_W-1:0]       status;
  logic signed [VALUE_W-1:0] out_value;
  logic                      out_valid;
  logic                      last;
  logic [TOTAL_W-1:0]        total_count;
  logic                      store_empty;

  multi_level_priority_fifo_top #(
    .LEVELS    (LEVELS),
    .CAPACITY  (CAPACITY),
    .MAX_REMOVE(MAX_REMOVE)
  ) u_top (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .opcode      (opcode),
    .level       (level),
    .target_level(target_level),
    .item_value  (item_value),
    .remove_count(remove_count),
    .strobe      (strobe),
    .status      (status),
    .out_value   (out_value),
    .out_valid   (out_valid),
    .last        (last),
    .total_count (total_count),
    .store_empty (store_empty)
  );

  // shadow copy of the linked node store
  logic signed [VALUE_W-1:0] node_val  [CAPACITY];
  int                        node_next [CAPACITY];
  int                        lvl_head  [LEVELS];
  int                        lvl_tail  [LEVELS];
  int                        lvl_size  [LEVELS];
  int                        free_top   = 0;
  int                        free_count = 0;
  int                        fresh_next = 0;
  int                        held       = 0;

  command_t pending_cmds[$];
  outcome_t expected_outcomes[$];
  command_t cur_cmd;
  outcome_t want;

  int errors       = 0;
  int sent         = 0;
  int op_seen[4]   = '{0, 0, 0, 0};
  int checked      = 0;
  int full_hits    = 0;
  int longest_run  = 0;
  int quiet_cycles = 0;

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic void push_outcome(logic [STATUS_W-1:0] st, logic signed [VALUE_W-1:0] v,
                                       logic vld, logic lst);
    outcome_t o;
    o.status = st;
    o.value  = v;
    o.valid  = vld;
    o.last   = lst;
    o.total  = held[TOTAL_W-1:0];
    o.empty  = (held == 0);
    expected_outcomes.push_back(o);
  endfunction

  function automatic void apply_command(command_t c);
    int lv;
    int tg;
    int n;
    int take;
    logic signed [VALUE_W-1:0] run[$];
    lv = int'(c.lvl);
    tg = int'(c.dst);
    op_seen[c.op]++;
    case (c.op)
      OP_INSERT: begin
        if (lv >= LEVELS) begin
          push_outcome(ST_BAD_LEVEL, '0, 1'b0, 1'b1);
        end else if (held >= CAPACITY) begin
          full_hits++;
          push_outcome(ST_FULL, '0, 1'b0, 1'b1);
        end else begin
          // reuse a released node before touching fresh ones
          if (free_count > 0) begin
            n = free_top;
            free_top = node_next[n];
            free_count--;
          end else begin
            n = fresh_next;
            fresh_next++;
          end
          node_val[n]  = c.val;
          node_next[n] = 0;
          if (lvl_size[lv] == 0) lvl_head[lv] = n;
          else node_next[lvl_tail[lv]] = n;
          lvl_tail[lv] = n;
          lvl_size[lv]++;
          held++;
          push_outcome(ST_OK, '0, 1'b0, 1'b1);
        end
      end
      OP_REMOVE: begin
        if (lv >= LEVELS) begin
          push_outcome(ST_BAD_LEVEL, '0, 1'b0, 1'b1);
        end else if (lvl_size[lv] == 0 || c.cnt == 0) begin
          push_outcome(ST_EMPTY, '0, 1'b0, 1'b1);
        end else begin
          take = int'(c.cnt);
          if (take > lvl_size[lv]) take = lvl_size[lv];
          if (take > MAX_REMOVE) take = MAX_REMOVE;
          for (int i = 0; i < take; i++) begin
            n = lvl_head[lv];
            run.push_back(node_val[n]);
            lvl_head[lv] = node_next[n];
            node_next[n] = free_top;
            free_top = n;
            free_count++;
          end
          lvl_size[lv] -= take;
          if (lvl_size[lv] == 0) begin
            lvl_head[lv] = 0;
            lvl_tail[lv] = 0;
          end
          held -= take;
          if (take > longest_run) longest_run = take;
          // every result of the run reports the count after the whole removal
          for (int i = 0; i < take; i++) push_outcome(ST_OK, run[i], 1'b1, i == take - 1);
        end
      end
      OP_MOVE: begin
        if (lv >= LEVELS || tg >= LEVELS) begin
          push_outcome(ST_BAD_LEVEL, '0, 1'b0, 1'b1);
        end else if (lv == tg) begin
          push_outcome(ST_BAD_MOVE, '0, 1'b0, 1'b1);
        end else if (lvl_size[lv] == 0) begin
          push_outcome(ST_EMPTY, '0, 1'b0, 1'b1);
        end else begin
          if (lvl_size[tg] == 0) lvl_head[tg] = lvl_head[lv];
          else node_next[lvl_tail[tg]] = lvl_head[lv];
          lvl_tail[tg] = lvl_tail[lv];
          lvl_size[tg] += lvl_size[lv];
          lvl_size[lv] = 0;
          lvl_head[lv] = 0;
          lvl_tail[lv] = 0;
          push_outcome(ST_OK, '0, 1'b0, 1'b1);
        end
      end
      default: begin
        push_outcome(ST_BAD_MOVE, '0, 1'b0, 1'b1);
      end
    endcase
  endfunction

  function automatic void queue_cmd(logic [OP_W-1:0] op, int lv, int tg,
                                    logic signed [VALUE_W-1:0] v, int cnt);
    command_t c;
    c.op  = op;
    c.lvl = lv[LEVEL_W-1:0];
    c.dst = tg[LEVEL_W-1:0];
    c.val = v;
    c.cnt = cnt[COUNT_W-1:0];
    pending_cmds.push_back(c);
  endfunction

  function automatic void compare_field(string name, longint exp_v, longint act_v);
    if (exp_v != act_v) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
      errors++;
    end
  endfunction

  // command driver: hold the current transfer while busy, else maybe idle
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        apply_command(cur_cmd);
        sent++;
      end
      if (!start || !busy) begin
        if (pending_cmds.size() > 0 &&
            ((sent >= 200 && sent < 330) || $urandom_range(99) >= 36)) begin
          cur_cmd = pending_cmds.pop_front();
          start        <= 1'b1;
          opcode       <= cur_cmd.op;
          level        <= cur_cmd.lvl;
          target_level <= cur_cmd.dst;
          item_value   <= cur_cmd.val;
          remove_count <= cur_cmd.cnt;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst && strobe) begin
      if (expected_outcomes.size() == 0) begin
        $error("result with nothing expected: status %0d value %0d", status, out_value);
        errors++;
      end else begin
        want = expected_outcomes.pop_front();
        checked++;
        compare_field("status", longint'(want.status), longint'(status));
        compare_field("out_value", longint'(want.value), longint'(out_value));
        compare_field("out_valid", longint'(want.valid), longint'(out_valid));
        compare_field("last", longint'(want.last), longint'(last));
        compare_field("total_count", longint'(want.total), longint'(total_count));
        compare_field("store_empty", longint'(want.empty), longint'(store_empty));
      end
    end
  end

  // watchdog: give up after a long stretch with no transfer in either direction
  always @(posedge clk) begin
    if (rst || (start && !busy) || strobe) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("timeout: %0d expected results outstanding", expected_outcomes.size());
      $display("multi_level_priority_fifo_top_test failed");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < CAPACITY; i++) begin
      node_val[i]  = '0;
      node_next[i] = 0;
    end
    for (int i = 0; i < LEVELS; i++) begin
      lvl_head[i] = 0;
      lvl_tail[i] = 0;
      lvl_size[i] = 0;
    end

    // directed: errors on an empty store, extremes, splices, capped removal
    queue_cmd(OP_REMOVE, 0, 0, 0, 5);
    queue_cmd(OP_MOVE, 0, 1, 0, 0);
    queue_cmd(OP_INSERT, 0, 0, 32'sh7FFF_FFFF, 0);
    queue_cmd(OP_INSERT, 0, 0, 32'sh8000_0000, 0);
    queue_cmd(OP_INSERT, 0, 0, 0, 0);
    queue_cmd(OP_INSERT, 0, 0, -1, 0);
    queue_cmd(OP_INSERT, 7, 0, 32'sh1234_5678, 0);
    queue_cmd(OP_INSERT, 8, 0, 5, 0);
    queue_cmd(OP_INSERT, 15, 15, 6, 0);
    queue_cmd(OP_REMOVE, 0, 0, 0, 0);
    queue_cmd(OP_REMOVE, 9, 0, 0, 3);
    queue_cmd(OP_MOVE, 0, 0, 0, 0);
    queue_cmd(OP_MOVE, 0, 12, 0, 0);
    queue_cmd(OP_MOVE, 10, 3, 0, 0);
    queue_cmd(OP_SPARE, 15, 15, -1, 127);
    queue_cmd(OP_MOVE, 0, 7, 0, 0);
    queue_cmd(OP_MOVE, 7, 2, 0, 0);
    queue_cmd(OP_REMOVE, 2, 0, 0, 2);
    queue_cmd(OP_INSERT, 2, 0, 32'sh5A5A_A5A5, 0);
    queue_cmd(OP_REMOVE, 2, 0, 0, 127);
    queue_cmd(OP_REMOVE, 2, 0, 0, 1);

    // mixed traffic with some noise
    for (int i = 0; i < 150; i++) begin
      int pick;
      int cnt;
      pick = $urandom_range(99);
      cnt  = ($urandom_range(9) == 0) ? $urandom_range(127) : $urandom_range(8, 1);
      if (pick < 45) queue_cmd(OP_INSERT, $urandom_range(7), 0, $urandom, 0);
      else if (pick < 75) queue_cmd(OP_REMOVE, $urandom_range(7), 0, 0, cnt);
      else if (pick < 90) queue_cmd(OP_MOVE, $urandom_range(7), $urandom_range(7), 0, 0);
      else queue_cmd(OP_W'($urandom_range(3)), $urandom_range(15), $urandom_range(15),
                     $urandom, cnt);
    end

    // fill past capacity, level 0 taking about half
    for (int i = 0; i < 290; i++)
      queue_cmd(OP_INSERT, $urandom_range(1) ? 0 : $urandom_range(7, 1), 0, $urandom, 0);

    // gather everything on level 0 and drain in full-size runs
    for (int i = 1; i < LEVELS; i++) queue_cmd(OP_MOVE, i, 0, 0, 0);
    queue_cmd(OP_REMOVE, 0, 0, 0, 64);
    queue_cmd(OP_REMOVE, 0, 0, 0, 127);
    queue_cmd(OP_REMOVE, 0, 0, 0, 64);
    queue_cmd(OP_REMOVE, 0, 0, 0, 100);
    queue_cmd(OP_REMOVE, 0, 0, 0, 64);
    for (int i = 0; i < 20; i++) begin
      if (i % 2 == 0) queue_cmd(OP_INSERT, $urandom_range(7), 0, $urandom, 0);
      else queue_cmd(OP_REMOVE, $urandom_range(7), 0, 0, $urandom_range(127));
    end

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    while (pending_cmds.size() > 0 || start || expected_outcomes.size() > 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d commands: %0d insert, %0d remove, %0d move, %0d spare opcode",
             sent, op_seen[OP_INSERT], op_seen[OP_REMOVE], op_seen[OP_MOVE],
             op_seen[OP_SPARE]);
    $display("checked %0d results, %0d store-full rejections, longest removal run %0d",
             checked, full_hits, longest_run);
    if (errors == 0) begin
      $display("multi_level_priority_fifo_top_test passed");
    end else begin
      $display("multi_level_priority_fifo_top_test failed");
    end
    $finish;
  end

endmodule
